[rtl/apr_pkg.sv]
// apr_pkg: shared types and constants of the aging page replacement unit
// input and result word formats, operation codes, controller states,
// and the command and status groups between controller and datapath
package apr_pkg;

  localparam logic [1:0] OP_REFERENCE = 2'd0;
  localparam logic [1:0] OP_SELECT    = 2'd1;
  localparam logic [1:0] OP_CLEAR     = 2'd2;

  localparam int         CFG_BITS        = 8;
  localparam logic [7:0] FIU_RESET       = 8'd128;
  localparam int         APB_DATA_BITS   = 32;
  localparam int         APB_ADDR_BITS   = 2;

  typedef struct packed {
    logic [1:0] operation;
    logic [6:0] frame_index;
  } in_item_t;

  typedef struct packed {
    logic [6:0]  victim_frame;
    logic [31:0] victim_age;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_REF_WR,
    ST_MOD,
    ST_PREP,
    ST_SCAN,
    ST_FINISH
  } apr_state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic sweep;
    logic ref_read;
    logic ref_write;
    logic clr_write;
    logic mod_start;
    logic mod_step;
    logic scan_start;
    logic scan_run;
    logic finish;
  } apr_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic sweep_last;
    logic idx_ok;
    logic mod_last;
    logic scan_done;
    logic out_free;
  } apr_status_t;

endpackage

[rtl/apr_ram.sv]
// apr_ram: generic simple dual-port ram, one write port, one read port
// read data is registered; no dependencies
module apr_ram #(
  parameter int WIDTH = 33,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/apr_ctrl.sv]
// apr_ctrl: controller state machine of the aging page replacement unit
// sequences clearing sweep, reference, clear and select; uses apr_pkg
module apr_ctrl
  import apr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic [1:0]  in_op,
  input  apr_status_t status,
  output apr_cmd_t    cmd,
  output logic        in_stall
);

  apr_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_SWEEP;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = (state != ST_IDLE);
    unique case (state)
      ST_SWEEP: begin
        cmd.sweep = 1'b1;
        if (status.sweep_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          unique case (in_op)
            OP_REFERENCE: begin
              if (status.idx_ok) begin
                cmd.ref_read = 1'b1;
                state_next   = ST_REF_WR;
              end
            end
            OP_CLEAR: begin
              cmd.clr_write = status.idx_ok;
            end
            OP_SELECT: begin
              cmd.mod_start = 1'b1;
              state_next    = ST_MOD;
            end
            default: ;
          endcase
        end
      end
      ST_REF_WR: begin
        cmd.ref_write = 1'b1;
        state_next    = ST_IDLE;
      end
      ST_MOD: begin
        cmd.mod_step = 1'b1;
        if (status.mod_last) begin
          state_next = ST_PREP;
        end
      end
      ST_PREP: begin
        cmd.scan_start = 1'b1;
        state_next     = ST_SCAN;
      end
      ST_SCAN: begin
        cmd.scan_run = 1'b1;
        if (status.scan_done) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        // hold the victim until the result register can take it
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

[rtl/apr_dp.sv]
// apr_dp: datapath of the aging page replacement unit
// frame ram, hand, remainder unit, scan pipeline, result register; uses apr_pkg, apr_ram
module apr_dp
  import apr_pkg::*;
#(
  parameter int MAX_FRAMES = 128,
  parameter int AGE_BITS   = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  apr_cmd_t            cmd,
  output apr_status_t         status,
  input  in_item_t            in_data,
  input  logic [CFG_BITS-1:0] frames_in_use,
  output logic                out_valid,
  input  logic                out_stall,
  output out_item_t           out_data
);

  localparam int FW  = $clog2(MAX_FRAMES);
  localparam int CW  = $clog2(MAX_FRAMES + 1);
  localparam int BW  = (FW > 1) ? $clog2(FW) : 1;
  localparam int NW  = (CW > CFG_BITS) ? CW : CFG_BITS;
  localparam int IXW = (FW > 7) ? FW + 1 : 8;
  localparam int SW  = FW + CW;
  localparam int WW  = AGE_BITS + 1;

  // ram word: referenced bit above the age
  logic              we;
  logic [FW-1:0]     waddr;
  logic [WW-1:0]     wdata;
  logic [FW-1:0]     raddr;
  logic [WW-1:0]     rdata;

  logic [FW-1:0]     sweep_cnt;
  logic [FW-1:0]     idx_reg;
  logic [FW-1:0]     hand;
  logic [CW-1:0]     n_reg;
  logic [CW-1:0]     n_calc;
  logic [FW-1:0]     rem;
  logic [BW-1:0]     mod_bit;
  logic [SW-1:0]     mod_sub;
  logic [FW-1:0]     rd_frame;
  logic [CW-1:0]     issued;
  logic              issuing;
  logic              stage_vld;
  logic              stage_first;
  logic [FW-1:0]     stage_frame;
  logic [AGE_BITS-1:0] new_age;
  logic [FW-1:0]     best_frame;
  logic [AGE_BITS-1:0] best_age;
  logic [CW-1:0]     best_inc;
  logic [CW-1:0]     rd_inc;
  logic [FW-1:0]     in_addr;

  apr_ram #(.WIDTH(WW), .DEPTH(MAX_FRAMES)) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign in_addr = FW'(in_data.frame_index);
  assign status.idx_ok     = IXW'(in_data.frame_index) < IXW'(MAX_FRAMES);
  assign status.sweep_last = (sweep_cnt == FW'(MAX_FRAMES - 1));
  assign status.mod_last   = (mod_bit == '0);
  assign issuing           = (issued != n_reg);
  assign status.scan_done  = !issuing && !stage_vld;
  assign status.out_free   = !out_valid || !out_stall;

  // zero and oversized register values are pinned into range
  always_comb begin
    if (frames_in_use == '0) begin
      n_calc = CW'(1);
    end else if (NW'(frames_in_use) > NW'(MAX_FRAMES)) begin
      n_calc = CW'(MAX_FRAMES);
    end else begin
      n_calc = CW'(frames_in_use);
    end
  end

  assign new_age  = {rdata[AGE_BITS], rdata[AGE_BITS-1:1]};
  assign mod_sub  = SW'(n_reg) << mod_bit;
  assign rd_inc   = CW'(rd_frame) + CW'(1);
  assign best_inc = CW'(best_frame) + CW'(1);

  assign raddr = cmd.ref_read ? in_addr : rd_frame;

  always_comb begin
    we    = 1'b0;
    waddr = stage_frame;
    wdata = {1'b0, new_age};
    if (cmd.sweep) begin
      we    = 1'b1;
      waddr = sweep_cnt;
      wdata = '0;
    end else if (cmd.ref_write) begin
      we    = 1'b1;
      waddr = idx_reg;
      wdata = {1'b1, rdata[AGE_BITS-1:0]};
    end else if (cmd.clr_write) begin
      we    = 1'b1;
      waddr = in_addr;
      wdata = '0;
    end else if (stage_vld) begin
      we    = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_cnt <= '0;
      hand      <= '0;
      issued    <= '0;
      n_reg     <= CW'(1);
      mod_bit   <= '0;
      stage_vld <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.sweep) begin
        sweep_cnt <= sweep_cnt + FW'(1);
      end
      if (cmd.ref_read) begin
        idx_reg <= in_addr;
      end
      // restoring remainder of the hand by the frame count, one bit a cycle
      if (cmd.mod_start) begin
        n_reg   <= n_calc;
        rem     <= hand;
        mod_bit <= BW'(FW - 1);
      end else if (cmd.mod_step) begin
        if (SW'(rem) >= mod_sub) begin
          rem <= rem - FW'(mod_sub);
        end
        mod_bit <= mod_bit - BW'(1);
      end
      if (cmd.scan_start) begin
        rd_frame <= rem;
        issued   <= '0;
      end
      stage_vld <= 1'b0;
      if (cmd.scan_run && issuing) begin
        stage_vld   <= 1'b1;
        stage_frame <= rd_frame;
        stage_first <= (issued == '0);
        issued      <= issued + CW'(1);
        rd_frame    <= (rd_inc == n_reg) ? '0 : rd_frame + FW'(1);
      end
      if (stage_vld && (stage_first || new_age < best_age)) begin
        best_frame <= stage_frame;
        best_age   <= new_age;
      end
      if (cmd.finish) begin
        hand      <= (best_inc == n_reg) ? '0 : best_frame + FW'(1);
        out_valid <= 1'b1;
        out_data.victim_frame <= 7'(best_frame);
        out_data.victim_age   <= 32'(best_age);
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_stage_in_range: assert property (@(posedge clk) disable iff (rst)
    stage_vld |-> CW'(stage_frame) < n_reg)
    else $error("scan touched a frame outside the frames in use");
  a_start_reduced: assert property (@(posedge clk) disable iff (rst)
    cmd.scan_start |-> CW'(rem) < n_reg)
    else $error("scan start not reduced below the frame count");
  a_hand_in_range: assert property (@(posedge clk) disable iff (rst)
    $past(cmd.finish) |-> CW'(hand) < n_reg)
    else $error("hand left outside the frames in use");
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> !(out_valid && out_stall))
    else $error("pending result overwritten");
`endif

endmodule

[rtl/aging_page_replacement_unit.sv]
// aging_page_replacement_unit: top level of the aging page replacement engine
// joins apr_ctrl and apr_dp and holds the frames_in_use register; uses apr_pkg
//
// usage:
//   in channel (in_valid, in_stall, in_data) takes one word per operation:
//   reference a frame, select a victim, or clear a frame on a new mapping.
//   out channel (out_valid, out_stall, out_data) carries one word per select:
//   the victim frame and its age after this scan's aging step.
//   apb port holds frames_in_use at address 0; write it only while idle.
// operations, with n frames in use:
//   reference reads then writes back the frame ram word,
//   clear and ignored codes are done without leaving the idle state,
//   select first reduces the hand modulo n bit by bit,
//   then the scan walks one frame per cycle through the ram read port,
//   writing the aged word back from a registered stage.
// after reset the unit sweeps all MAX_FRAMES words of the frame ram to zero
// with in_stall high; the register port works during the sweep.
// a result waits in the output register while out_stall is high; a new item
// is still taken, and only a following select finish waits for the slot.
module aging_page_replacement_unit
  import apr_pkg::*;
#(
  parameter int MAX_FRAMES = 128,
  parameter int AGE_BITS   = 32
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  in_item_t                 in_data,
  output logic                     out_valid,
  input  logic                     out_stall,
  output out_item_t                out_data,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [APB_ADDR_BITS-1:0] paddr,
  input  logic [APB_DATA_BITS-1:0] pwdata,
  output logic [APB_DATA_BITS-1:0] prdata,
  output logic                     pready
);

  apr_cmd_t            cmd;
  apr_status_t         status;
  logic [CFG_BITS-1:0] frames_in_use;

  // single register: every address in the word decodes to it
  always_ff @(posedge clk) begin
    if (rst) begin
      frames_in_use <= FIU_RESET;
    end else if (psel && penable && pwrite && (paddr <= '1)) begin
      frames_in_use <= pwdata[CFG_BITS-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = APB_DATA_BITS'(frames_in_use);

  apr_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_op   (in_data.operation),
    .status  (status),
    .cmd     (cmd),
    .in_stall(in_stall)
  );

  apr_dp #(
    .MAX_FRAMES(MAX_FRAMES),
    .AGE_BITS  (AGE_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .in_data      (in_data),
    .frames_in_use(frames_in_use),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data     (out_data)
  );

endmodule

[bench/tb.sv]
// tb: self-checking bench for aging_page_replacement_unit
// drives operation words and apb writes; predicts each victim word in place unless the plan pins it;
// depends on apr_pkg and the rtl of the unit only
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import apr_pkg::*;

  localparam int MAX_FRAMES = 128;
  localparam int SETTLE = 200;        // covers a full 128-frame select and then some
  localparam int HOLD_CYCLES = 400;
  localparam int PHASE_WORDS = 188;
  localparam int HOLD_PHASE = 2;
  localparam int CALM_PHASE = 5;
  localparam int PAUSE_PHASE = 6;
  localparam int RAND_PHASE = 8;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic [APB_ADDR_BITS-1:0] FIU_ADDR = '0;

  typedef enum logic {ROW_WORD, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t kind;
    in_item_t  word;
    logic [7:0] cfg;
    logic      known;
    out_item_t res;
  } row_t;

  typedef struct packed {
    logic      known;
    out_item_t res;
  } pin_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [APB_ADDR_BITS-1:0] paddr = '0;
  logic [APB_DATA_BITS-1:0] pwdata = '0;
  logic [APB_DATA_BITS-1:0] prdata;
  logic pready;

  aging_page_replacement_unit u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // mirror of the frame table
  logic [31:0] age_m [MAX_FRAMES] = '{default: '0};
  logic        ref_m [MAX_FRAMES] = '{default: 1'b0};
  int unsigned hand_m = 0;
  logic [7:0]  fiu_m = FIU_RESET;

  out_item_t victim_q [$];
  pin_t      known_q [$];
  int        errors = 0;
  logic      calm = 1'b0;
  int        hold_left = 0;

  row_t plan [25] = '{
    '{ROW_WORD, '{OP_SELECT,    7'd0},   8'd0,   1'b1, '{7'd0, 32'd0}},
    '{ROW_WORD, '{OP_UNUSED,    7'd127}, 8'd0,   1'b0, '0},
    '{ROW_WORD, '{OP_SELECT,    7'd127}, 8'd0,   1'b1, '{7'd1, 32'd0}},
    '{ROW_WORD, '{OP_REFERENCE, 7'd2},   8'd0,   1'b0, '0},
    '{ROW_WORD, '{OP_REFERENCE, 7'd127}, 8'd0,   1'b0, '0},
    '{ROW_WORD, '{OP_SELECT,    7'd0},   8'd0,   1'b1, '{7'd3, 32'd0}},
    '{ROW_WORD, '{OP_CLEAR,     7'd2},   8'd0,   1'b0, '0},
    '{ROW_WORD, '{OP_REFERENCE, 7'd0},   8'd0,   1'b0, '0},
    '{ROW_WORD, '{OP_CLEAR,     7'd127}, 8'd0,   1'b0, '0},
    '{ROW_WORD, '{OP_SELECT,    7'd85},  8'd0,   1'b0, '0},
    '{ROW_CFG,  '0,                      8'd3,   1'b0, '0},
    '{ROW_WORD, '{OP_SELECT,    7'd0},   8'd0,   1'b0, '0},
    '{ROW_WORD, '{OP_REFERENCE, 7'd100}, 8'd0,   1'b0, '0},
    '{ROW_WORD, '{OP_CLEAR,     7'd101}, 8'd0,   1'b0, '0},
    '{ROW_WORD, '{OP_SELECT,    7'd0},   8'd0,   1'b0, '0},
    '{ROW_CFG,  '0,                      8'd0,   1'b0, '0},
    '{ROW_WORD, '{OP_SELECT,    7'd42},  8'd0,   1'b0, '0},
    '{ROW_WORD, '{OP_REFERENCE, 7'd0},   8'd0,   1'b0, '0},
    '{ROW_WORD, '{OP_SELECT,    7'd0},   8'd0,   1'b0, '0},
    '{ROW_CFG,  '0,                      8'd255, 1'b0, '0},
    '{ROW_WORD, '{OP_SELECT,    7'd0},   8'd0,   1'b0, '0},
    '{ROW_CFG,  '0,                      8'd1,   1'b0, '0},
    '{ROW_WORD, '{OP_SELECT,    7'd0},   8'd0,   1'b0, '0},
    '{ROW_CFG,  '0,                      8'd128, 1'b0, '0},
    '{ROW_WORD, '{OP_SELECT,    7'd0},   8'd0,   1'b0, '0}
  };

  logic [7:0] fiu_plan [10] = '{8'd128, 8'd1, 8'd2, 8'd255, 8'd0,
                                8'd7, 8'd16, 8'd64, 8'd0, 8'd127};

  function automatic int unsigned frames_live(input logic [7:0] v);
    if (v == 8'd0) return 1;
    if (v > MAX_FRAMES) return MAX_FRAMES;
    return v;
  endfunction

  // applies one word to the mirror; returns 1 when it yields a victim word
  function automatic logic age_and_pick(input in_item_t w, output out_item_t res);
    int unsigned n;
    int unsigned start;
    int unsigned f;
    int unsigned best;
    logic [31:0] a;
    logic [31:0] best_age;
    res = '0;
    if (w.operation == OP_REFERENCE) begin
      ref_m[w.frame_index] = 1'b1;
      return 1'b0;
    end
    if (w.operation == OP_CLEAR) begin
      age_m[w.frame_index] = '0;
      ref_m[w.frame_index] = 1'b0;
      return 1'b0;
    end
    if (w.operation != OP_SELECT) return 1'b0;
    n = frames_live(fiu_m);
    start = hand_m % n;
    best = start;
    best_age = '0;
    for (int i = 0; i < n; i++) begin
      f = start + i;
      if (f >= n) f -= n;
      a = {ref_m[f], age_m[f][31:1]};
      ref_m[f] = 1'b0;
      age_m[f] = a;
      // strictly smaller only, so the earliest in scan order wins ties
      if (i == 0 || a < best_age) begin
        best = f;
        best_age = a;
      end
    end
    hand_m = (best + 1 >= n) ? 0 : best + 1;
    res.victim_frame = best[6:0];
    res.victim_age = best_age;
    return 1'b1;
  endfunction

  // output check first, then prediction of the word taken at the same edge
  always @(posedge clk) begin
    out_item_t want;
    out_item_t got;
    out_item_t guess;
    pin_t pin;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        got = out_data;
        if (victim_q.size() == 0) begin
          errors++;
          $error("victim word with none expected: frame %0d age %h",
                 got.victim_frame, got.victim_age);
        end else begin
          want = victim_q.pop_front();
          if (got.victim_frame !== want.victim_frame) begin
            errors++;
            $error("victim_frame: expected %0d, got %0d", want.victim_frame,
                   got.victim_frame);
          end
          if (got.victim_age !== want.victim_age) begin
            errors++;
            $error("victim_age: expected %h, got %h", want.victim_age, got.victim_age);
          end
        end
      end
      if (in_valid && !in_stall) begin
        pin = known_q.pop_front();
        if (age_and_pick(in_data, guess)) victim_q.push_back(pin.known ? pin.res : guess);
      end
    end
  end

  // receiver: random stalls, calm stretches, and a long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (calm) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(99) < 24);
      end
    end
  end

  task automatic offer(input in_item_t w, input logic known, input out_item_t res);
    known_q.push_back('{known, res});
    in_valid <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic idle_gap();
    if (!calm && $urandom_range(99) < 24) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  // stop offering until every victim word is in, then let trailing work settle
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (victim_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_fiu(input logic [7:0] v);
    logic [31:0] junk;
    junk = $urandom;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= FIU_ADDR;
    pwdata <= {junk[31:8], v};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    fiu_m = v;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata[7:0] !== v) begin
      errors++;
      $error("frames_in_use: expected %0d, got %0d", v, prdata[7:0]);
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  initial begin
    in_item_t w;
    int unsigned n_eff;
    int unsigned roll;
    logic [7:0] setting;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[r]) begin
      if (plan[r].kind == ROW_CFG) begin
        drain();
        write_fiu(plan[r].cfg);
      end else begin
        idle_gap();
        offer(plan[r].word, plan[r].known, plan[r].res);
      end
    end
    drain();

    foreach (fiu_plan[p]) begin
      setting = (p == RAND_PHASE) ? 8'($urandom_range(255)) : fiu_plan[p];
      write_fiu(setting);
      n_eff = frames_live(setting);
      calm = (p == CALM_PHASE);
      for (int k = 0; k < PHASE_WORDS; k++) begin
        if (p == HOLD_PHASE && k == 40) hold_left = HOLD_CYCLES;
        if (p == PAUSE_PHASE && k == PHASE_WORDS / 2) drain();
        roll = $urandom_range(99);
        w.operation = (roll < 48) ? OP_REFERENCE :
                      (roll < 73) ? OP_SELECT :
                      (roll < 92) ? OP_CLEAR : OP_UNUSED;
        // mostly frames that take part in the scan, some anywhere
        w.frame_index = ($urandom_range(99) < 85) ? 7'($urandom_range(n_eff - 1))
                                                  : 7'($urandom);
        idle_gap();
        offer(w, 1'b0, '0);
      end
      drain();
    end
    calm = 1'b0;

    if (errors == 0) begin
      $display("** aging_page_replacement_unit: PASSED **");
    end else begin
      $display("** aging_page_replacement_unit: FAILED **");
    end
    $finish;
  end

  initial begin
    #15ms;
    $display("** aging_page_replacement_unit: FAILED **");
    $finish;
  end

endmodule

[sim.f]
rtl/apr_pkg.sv
rtl/apr_ram.sv
rtl/apr_ctrl.sv
rtl/apr_dp.sv
rtl/aging_page_replacement_unit.sv
bench/tb.sv
